[rtl/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

[rtl/bba_pkg.sv]
// Package for the buddy block allocator: sizes, codes, types and helpers.
// Used by every module of the block except bba_ram; depends on nothing.
`default_nettype none

package bba_pkg;

    localparam int POOL_BYTES      = 65536;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int HEADER_BYTES    = 8;
    localparam int NUM_ORDERS      = 13;

    localparam int BLOCK_COUNT = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int TOP_ORDER   = NUM_ORDERS - 1;
    localparam int ENTRY_W     = $clog2(BLOCK_COUNT);
    localparam int LINK_W      = ENTRY_W + 1;
    localparam int ORD_W       = $clog2(NUM_ORDERS + 1);
    localparam int HIDX_W      = $clog2(NUM_ORDERS);
    localparam int MIN_SHIFT   = $clog2(MIN_BLOCK_BYTES);

    localparam int KIND_W     = 2;
    localparam int SIZE_W     = 17;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 17;
    localparam int NEED_W     = SIZE_W + 1;
    localparam int IN_DATA_W  = ((SIZE_W + HANDLE_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = STATUS_W + HANDLE_W + 1 + HANDLE_W + SIZE_W
                                + TOTAL_W + TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(BLOCK_COUNT);

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADH = 2'd2;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_H_RD, S_H_CHK, S_R_DEC, S_R_BRD, S_R_BCHK,
        S_R_GR_T1, S_R_GR_T2, S_R_GR_T3, S_R_GR_WR,
        S_R_SH_T1, S_R_SH_T2, S_R_SH_LOOP, S_R_SH_FREE, S_R_SH_WR, S_R_MV,
        S_A_ORD, S_A_SCAN, S_A_SPLIT, S_A_MARK, S_A_TOT1, S_A_TOT2,
        S_F_RD, S_F_START, S_F_T1, S_F_T2, S_F_BUD, S_F_BCHK, S_F_MERGE,
        S_RM_RD, S_RM_W1, S_RM_W2, S_PU_W1, S_PU_W2, S_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   request_size;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] result_handle;
        logic                copy_needed;
        logic [HANDLE_W-1:0] copy_source;
        logic [SIZE_W-1:0]   copy_length;
        logic [TOTAL_W-1:0]  bytes_allocated;
        logic [TOTAL_W-1:0]  bytes_free;
    } result_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] addr;
        logic               we_used;
        logic               we_order;
        logic               we_size;
        logic               we_prev;
        logic               we_next;
        logic               used;
        logic [ORD_W-1:0]   order;
        logic [SIZE_W-1:0]  size;
        logic [LINK_W-1:0]  prev;
        logic [LINK_W-1:0]  next;
    } mem_req_t;

    typedef struct packed {
        logic               used;
        logic [ORD_W-1:0]   order;
        logic [SIZE_W-1:0]  size;
        logic [LINK_W-1:0]  prev;
        logic [LINK_W-1:0]  next;
    } mem_rd_t;

    function automatic logic [NEED_W-1:0] cap_of(input logic [ORD_W-1:0] k);
        cap_of = NEED_W'(MIN_BLOCK_BYTES) << k;
    endfunction

    function automatic logic [HANDLE_W-1:0] handle_of(input logic [ENTRY_W-1:0] e);
        handle_of = HANDLE_W'((32'(e) << MIN_SHIFT) + 32'(HEADER_BYTES));
    endfunction

endpackage

`default_nettype wire

[rtl/bba_ram.sv]
// Generic single-port RAM with a registered read.
// Stands alone; the allocator's metadata store instantiates it.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/bba_store.sv]
// Per-block metadata store: used, order, size and the two list links.
// Depends on bba_pkg and bba_ram; entry zero reads its reset value until written.
`default_nettype none

module bba_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bba_pkg::mem_req_t req,
    output      bba_pkg::mem_rd_t  rd
);
    import bba_pkg::*;

    logic               used_q;
    logic [ORD_W-1:0]   order_q;
    logic [SIZE_W-1:0]  size_q;
    logic [LINK_W-1:0]  prev_q;
    logic [LINK_W-1:0]  next_q;
    logic [ENTRY_W-1:0] addr_reg;
    logic               fresh_used_reg, fresh_order_reg, fresh_prev_reg, fresh_next_reg;
    logic               at_zero, rd_zero;

    bba_ram #(.WIDTH(1), .DEPTH(BLOCK_COUNT)) u_used (
        .clk(clk), .we(req.we_used), .addr(req.addr), .wdata(req.used), .rdata(used_q));
    bba_ram #(.WIDTH(ORD_W), .DEPTH(BLOCK_COUNT)) u_order (
        .clk(clk), .we(req.we_order), .addr(req.addr), .wdata(req.order), .rdata(order_q));
    bba_ram #(.WIDTH(SIZE_W), .DEPTH(BLOCK_COUNT)) u_size (
        .clk(clk), .we(req.we_size), .addr(req.addr), .wdata(req.size), .rdata(size_q));
    bba_ram #(.WIDTH(LINK_W), .DEPTH(BLOCK_COUNT)) u_prev (
        .clk(clk), .we(req.we_prev), .addr(req.addr), .wdata(req.prev), .rdata(prev_q));
    bba_ram #(.WIDTH(LINK_W), .DEPTH(BLOCK_COUNT)) u_next (
        .clk(clk), .we(req.we_next), .addr(req.addr), .wdata(req.next), .rdata(next_q));

    assign at_zero = (req.addr == '0);
    assign rd_zero = (addr_reg == '0);

    always_ff @(posedge clk)
    begin
        addr_reg <= req.addr;
    end

    // Entry zero starts as the lone free top-order block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_used_reg  <= 1'b1;
            fresh_order_reg <= 1'b1;
            fresh_prev_reg  <= 1'b1;
            fresh_next_reg  <= 1'b1;
        end
        else
        begin
            if (req.we_used && at_zero)  fresh_used_reg  <= 1'b0;
            if (req.we_order && at_zero) fresh_order_reg <= 1'b0;
            if (req.we_prev && at_zero)  fresh_prev_reg  <= 1'b0;
            if (req.we_next && at_zero)  fresh_next_reg  <= 1'b0;
        end
    end

    always_comb
    begin
        rd.used  = (rd_zero && fresh_used_reg)  ? 1'b0 : used_q;
        rd.order = (rd_zero && fresh_order_reg) ? ORD_W'(TOP_ORDER) : order_q;
        rd.size  = size_q;
        rd.prev  = (rd_zero && fresh_prev_reg)  ? NIL : prev_q;
        rd.next  = (rd_zero && fresh_next_reg)  ? NIL : next_q;
    end

endmodule

`default_nettype wire

[rtl/bba_alu.sv]
// Shared adder and subtractor used for request sizes and byte totals.
// Depends on bba_pkg.
`default_nettype none

module bba_alu (
    input  wire bba_pkg::alu_op_t           op,
    input  wire logic [bba_pkg::NEED_W-1:0] a,
    input  wire logic [bba_pkg::NEED_W-1:0] b,
    output      logic [bba_pkg::NEED_W-1:0] y
);
    import bba_pkg::*;

    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a;
        endcase
    end

endmodule

`default_nettype wire

[rtl/bba_ctrl.sv]
// Request sequencer: walks alloc, free and realloc one memory access a step.
// Depends on bba_pkg, bba_store, bba_alu and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bba_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bba_pkg::req_t    req,
    output      logic             idle,
    output      logic             done,
    input  wire logic             ack,
    output      bba_pkg::result_t result
);
    import bba_pkg::*;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [HANDLE_W-1:0] h_reg, h_next;
    logic [ENTRY_W-1:0]  cur_reg, cur_next, hold_reg, hold_next, b_reg, b_next;
    logic [ENTRY_W-1:0]  pu_x_reg, pu_x_next, rm_x_reg, rm_x_next;
    logic [ORD_W-1:0]    k_reg, k_next, i_reg, i_next, pu_k_reg, pu_k_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [SIZE_W-1:0]   old_reg, old_next;
    logic [LINK_W-1:0]   lp_reg, lp_next, ln_reg, ln_next;
    logic [LINK_W-1:0]   head_reg [NUM_ORDERS];
    logic [LINK_W-1:0]   head_next [NUM_ORDERS];
    logic [TOTAL_W-1:0]  alloc_reg, alloc_next, free_reg, free_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] rh_reg, rh_next, src_reg, src_next;
    logic                copy_reg, copy_next;
    logic [SIZE_W-1:0]   len_reg, len_next;

    mem_req_t            mreq;
    mem_rd_t             rd;
    alu_op_t             alu_op;
    logic [NEED_W-1:0]   alu_a, alu_b, alu_y;

    logic [ORD_W-1:0]    head_idx;
    logic [LINK_W-1:0]   head_rd;
    logic [NEED_W-1:0]   cap_k, cap_km1;
    logic [LINK_W-1:0]   span_k, cur_ext;
    logic [LINK_W:0]     bsum;
    logic [ENTRY_W-1:0]  bud;
    logic                bound_bad, fits, grow_try, shrink_more;
    logic [HANDLE_W-1:0] off;
    logic                handle_ok;
    logic [ORD_W-1:0]    i_dec, k_dec;

    bba_store u_store (.clk(clk), .rst_n(rst_n), .req(mreq), .rd(rd));
    bba_alu   u_alu   (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

    assign head_idx  = (state_reg == S_PU_W1) ? pu_k_reg : i_reg;
    assign head_rd   = head_reg[head_idx[HIDX_W-1:0]];
    assign cap_k     = cap_of(k_reg);
    assign k_dec     = k_reg - ORD_W'(1);
    assign i_dec     = i_reg - ORD_W'(1);
    assign cap_km1   = cap_of(k_dec);
    assign span_k    = LINK_W'(1) << k_reg;
    assign cur_ext   = {1'b0, cur_reg};
    assign bsum      = {1'b0, cur_ext} + {span_k, 1'b0};
    assign bud       = cur_reg ^ span_k[ENTRY_W-1:0];
    assign bound_bad = ((cur_ext & span_k) == '0) && (bsum > (LINK_W + 1)'(BLOCK_COUNT));
    assign fits      = (need_reg <= cap_k);
    assign grow_try  = !fits && (need_reg <= {cap_k[NEED_W-2:0], 1'b0})
                       && ((cur_ext & span_k) == '0)
                       && (k_reg < ORD_W'(TOP_ORDER)) && !bound_bad;
    assign shrink_more = (k_reg != '0) && (cap_km1 >= need_reg);
    assign off       = h_reg - HANDLE_W'(HEADER_BYTES);
    assign handle_ok = (h_reg >= HANDLE_W'(HEADER_BYTES))
                       && (off[MIN_SHIFT-1:0] == '0)
                       && ((off >> MIN_SHIFT) < HANDLE_W'(BLOCK_COUNT));

    assign idle = (state_reg == S_IDLE);
    assign result.status          = status_reg;
    assign result.result_handle   = rh_reg;
    assign result.copy_needed     = copy_reg;
    assign result.copy_source     = src_reg;
    assign result.copy_length     = len_reg;
    assign result.bytes_allocated = alloc_reg;
    assign result.bytes_free      = free_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (start) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (kind_reg == KIND_ALLOC)
                    state_next = S_A_ORD;
                else if (kind_reg == KIND_FREE || kind_reg == KIND_REALLOC)
                    state_next = handle_ok ? S_H_RD : S_DONE;
                else
                    state_next = S_DONE;
            end
            S_H_RD:      state_next = S_H_CHK;
            S_H_CHK:
            begin
                if (!rd.used)
                    state_next = S_DONE;
                else if (kind_reg == KIND_FREE || size_reg == '0)
                    state_next = S_F_RD;
                else
                    state_next = S_R_DEC;
            end
            S_R_DEC:
            begin
                if (fits)
                    state_next = S_R_SH_T1;
                else if (grow_try)
                    state_next = S_R_BRD;
                else
                    state_next = S_A_ORD;
            end
            S_R_BRD:     state_next = S_R_BCHK;
            S_R_BCHK:    state_next = (!rd.used && rd.order == k_reg) ? S_R_GR_T1 : S_A_ORD;
            S_R_GR_T1:   state_next = S_R_GR_T2;
            S_R_GR_T2:   state_next = S_R_GR_T3;
            S_R_GR_T3:   state_next = S_RM_RD;
            S_R_GR_WR:   state_next = S_DONE;
            S_R_SH_T1:   state_next = S_R_SH_T2;
            S_R_SH_T2:   state_next = S_R_SH_LOOP;
            S_R_SH_LOOP: state_next = shrink_more ? S_PU_W1 : S_R_SH_WR;
            S_R_SH_FREE: state_next = S_R_SH_LOOP;
            S_R_SH_WR:   state_next = S_DONE;
            S_R_MV:      state_next = S_F_RD;
            S_A_ORD:
            begin
                if (k_reg > ORD_W'(TOP_ORDER))
                    state_next = S_DONE;
                else if (cap_k >= need_reg)
                    state_next = S_A_SCAN;
            end
            S_A_SCAN:
            begin
                if (i_reg > ORD_W'(TOP_ORDER))
                    state_next = S_DONE;
                else if (head_rd < NIL)
                    state_next = S_RM_RD;
            end
            S_A_SPLIT:   state_next = (i_reg > k_reg) ? S_PU_W1 : S_A_MARK;
            S_A_MARK:    state_next = S_A_TOT1;
            S_A_TOT1:    state_next = S_A_TOT2;
            S_A_TOT2:    state_next = (kind_reg == KIND_REALLOC) ? S_R_MV : S_DONE;
            S_F_RD:      state_next = S_F_START;
            S_F_START:   state_next = S_F_T1;
            S_F_T1:      state_next = S_F_T2;
            S_F_T2:      state_next = S_F_BUD;
            S_F_BUD:
                state_next = (k_reg >= ORD_W'(TOP_ORDER) || bound_bad) ? S_PU_W1 : S_F_BCHK;
            S_F_BCHK:    state_next = (!rd.used && rd.order == k_reg) ? S_RM_RD : S_PU_W1;
            S_F_MERGE:   state_next = S_F_BUD;
            S_RM_RD:     state_next = S_RM_W1;
            S_RM_W1:     state_next = (rd.next < NIL) ? S_RM_W2 : ret_reg;
            S_RM_W2:     state_next = ret_reg;
            S_PU_W1:     state_next = (head_rd < NIL) ? S_PU_W2 : ret_reg;
            S_PU_W2:     state_next = ret_reg;
            S_DONE:      if (ack) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Memory and arithmetic controls.
    always_comb
    begin
        mreq   = '0;
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        done   = 1'b0;
        case (state_reg)
            S_DISPATCH:
            begin
                alu_a = NEED_W'(size_reg);
                alu_b = NEED_W'(HEADER_BYTES);
            end
            S_H_RD, S_F_RD: mreq.addr = cur_reg;
            S_R_BRD:        mreq.addr = b_reg;
            S_R_GR_T1, S_R_SH_T1, S_A_TOT1:
            begin
                alu_a = NEED_W'(alloc_reg);
                alu_b = NEED_W'(size_reg);
            end
            S_R_GR_T2, S_R_SH_T2, S_F_T1:
            begin
                alu_op = ALU_SUB;
                alu_a  = NEED_W'(alloc_reg);
                alu_b  = NEED_W'(old_reg);
            end
            S_R_GR_T3, S_A_TOT2:
            begin
                alu_op = ALU_SUB;
                alu_a  = NEED_W'(free_reg);
                alu_b  = cap_k;
            end
            S_R_SH_FREE, S_F_T2:
            begin
                alu_a = NEED_W'(free_reg);
                alu_b = cap_k;
            end
            S_R_GR_WR:
            begin
                mreq.addr     = cur_reg;
                mreq.we_order = 1'b1;
                mreq.order    = k_reg + ORD_W'(1);
                mreq.we_size  = 1'b1;
                mreq.size     = size_reg;
            end
            S_R_SH_WR:
            begin
                mreq.addr     = cur_reg;
                mreq.we_order = 1'b1;
                mreq.order    = k_reg;
                mreq.we_size  = 1'b1;
                mreq.size     = size_reg;
            end
            S_A_MARK:
            begin
                mreq.addr     = cur_reg;
                mreq.we_used  = 1'b1;
                mreq.used     = 1'b1;
                mreq.we_order = 1'b1;
                mreq.order    = k_reg;
                mreq.we_size  = 1'b1;
                mreq.size     = size_reg;
            end
            S_F_START:
            begin
                mreq.addr    = cur_reg;
                mreq.we_used = 1'b1;
                mreq.used    = 1'b0;
            end
            S_F_BUD:  mreq.addr = bud;
            S_RM_RD:  mreq.addr = rm_x_reg;
            S_RM_W1:
            begin
                if (rd.prev < NIL)
                begin
                    mreq.addr    = rd.prev[ENTRY_W-1:0];
                    mreq.we_next = 1'b1;
                    mreq.next    = rd.next;
                end
            end
            S_RM_W2:
            begin
                mreq.addr    = ln_reg[ENTRY_W-1:0];
                mreq.we_prev = 1'b1;
                mreq.prev    = lp_reg;
            end
            S_PU_W1:
            begin
                mreq.addr     = pu_x_reg;
                mreq.we_used  = 1'b1;
                mreq.used     = 1'b0;
                mreq.we_order = 1'b1;
                mreq.order    = pu_k_reg;
                mreq.we_prev  = 1'b1;
                mreq.prev     = NIL;
                mreq.we_next  = 1'b1;
                mreq.next     = head_rd;
            end
            S_PU_W2:
            begin
                mreq.addr    = ln_reg[ENTRY_W-1:0];
                mreq.we_prev = 1'b1;
                mreq.prev    = {1'b0, pu_x_reg};
            end
            S_DONE:   done = 1'b1;
            default:  mreq = '0;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        ret_next    = ret_reg;
        kind_next   = kind_reg;
        size_next   = size_reg;
        h_next      = h_reg;
        cur_next    = cur_reg;
        hold_next   = hold_reg;
        b_next      = b_reg;
        pu_x_next   = pu_x_reg;
        rm_x_next   = rm_x_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        pu_k_next   = pu_k_reg;
        need_next   = need_reg;
        old_next    = old_reg;
        lp_next     = lp_reg;
        ln_next     = ln_reg;
        alloc_next  = alloc_reg;
        free_next   = free_reg;
        status_next = status_reg;
        rh_next     = rh_reg;
        copy_next   = copy_reg;
        src_next    = src_reg;
        len_next    = len_reg;
        for (int j = 0; j < NUM_ORDERS; j++)
            head_next[j] = head_reg[j];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = req.kind;
                    size_next   = req.request_size;
                    h_next      = req.handle;
                    status_next = ST_OK;
                    rh_next     = '0;
                    copy_next   = 1'b0;
                    src_next    = '0;
                    len_next    = '0;
                end
            end
            S_DISPATCH:
            begin
                need_next = alu_y;
                k_next    = '0;
                cur_next  = ENTRY_W'(off >> MIN_SHIFT);
                hold_next = ENTRY_W'(off >> MIN_SHIFT);
                if ((kind_reg == KIND_FREE || kind_reg == KIND_REALLOC) && !handle_ok)
                    status_next = ST_BADH;
            end
            S_H_CHK:
            begin
                k_next   = rd.order;
                old_next = rd.size;
                if (!rd.used)
                    status_next = ST_BADH;
            end
            S_R_DEC:
            begin
                b_next = bud;
                if (!fits && !grow_try)
                    k_next = '0;
            end
            S_R_BCHK:
                if (!(!rd.used && rd.order == k_reg))
                    k_next = '0;
            S_R_GR_T1, S_R_SH_T1, S_R_GR_T2, S_R_SH_T2, S_A_TOT1, S_F_T1:
                alloc_next = alu_y[TOTAL_W-1:0];
            S_R_GR_T3:
            begin
                free_next = alu_y[TOTAL_W-1:0];
                rm_x_next = b_reg;
                ret_next  = S_R_GR_WR;
            end
            S_R_SH_FREE, S_F_T2:
                free_next = alu_y[TOTAL_W-1:0];
            S_R_GR_WR, S_R_SH_WR: rh_next = h_reg;
            S_R_SH_LOOP:
            begin
                if (shrink_more)
                begin
                    k_next    = k_dec;
                    pu_k_next = k_dec;
                    pu_x_next = cur_reg + ENTRY_W'(LINK_W'(1) << k_dec);
                    ret_next  = S_R_SH_FREE;
                end
            end
            S_R_MV:
            begin
                copy_next = 1'b1;
                src_next  = h_reg;
                len_next  = old_reg;
                cur_next  = hold_reg;
            end
            S_A_ORD:
            begin
                if (k_reg > ORD_W'(TOP_ORDER))
                    status_next = ST_OOM;
                else if (cap_k < need_reg)
                    k_next = k_reg + ORD_W'(1);
                else
                    i_next = k_reg;
            end
            S_A_SCAN:
            begin
                if (i_reg > ORD_W'(TOP_ORDER))
                    status_next = ST_OOM;
                else if (head_rd >= NIL)
                    i_next = i_reg + ORD_W'(1);
                else
                begin
                    cur_next  = head_rd[ENTRY_W-1:0];
                    rm_x_next = head_rd[ENTRY_W-1:0];
                    ret_next  = S_A_SPLIT;
                end
            end
            S_A_SPLIT:
            begin
                if (i_reg > k_reg)
                begin
                    i_next    = i_dec;
                    pu_k_next = i_dec;
                    pu_x_next = cur_reg + ENTRY_W'(LINK_W'(1) << i_dec);
                    ret_next  = S_A_SPLIT;
                end
            end
            S_A_TOT2:
            begin
                free_next = alu_y[TOTAL_W-1:0];
                rh_next   = handle_of(cur_reg);
            end
            S_F_START:
            begin
                k_next   = rd.order;
                old_next = rd.size;
            end
            S_F_BUD:
            begin
                b_next = bud;
                if (k_reg >= ORD_W'(TOP_ORDER) || bound_bad)
                begin
                    pu_k_next = k_reg;
                    pu_x_next = cur_reg;
                    ret_next  = S_DONE;
                end
            end
            S_F_BCHK:
            begin
                if (!rd.used && rd.order == k_reg)
                begin
                    rm_x_next = b_reg;
                    ret_next  = S_F_MERGE;
                end
                else
                begin
                    pu_k_next = k_reg;
                    pu_x_next = cur_reg;
                    ret_next  = S_DONE;
                end
            end
            S_F_MERGE:
            begin
                if (b_reg < cur_reg)
                    cur_next = b_reg;
                k_next = k_reg + ORD_W'(1);
            end
            S_RM_W1:
            begin
                lp_next = rd.prev;
                ln_next = rd.next;
                if (rd.prev >= NIL && rd.order < ORD_W'(NUM_ORDERS))
                    head_next[rd.order[HIDX_W-1:0]] = rd.next;
            end
            S_PU_W1:
            begin
                ln_next = head_rd;
                head_next[pu_k_reg[HIDX_W-1:0]] = {1'b0, pu_x_reg};
            end
            default: ret_next = ret_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            alloc_reg <= '0;
            free_reg  <= TOTAL_W'(POOL_BYTES);
            for (int j = 0; j < NUM_ORDERS; j++)
                head_reg[j] <= (j == TOP_ORDER) ? LINK_W'(0) : NIL;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            alloc_reg <= alloc_next;
            free_reg  <= free_next;
            for (int j = 0; j < NUM_ORDERS; j++)
                head_reg[j] <= head_next[j];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        size_reg   <= size_next;
        h_reg      <= h_next;
        cur_reg    <= cur_next;
        hold_reg   <= hold_next;
        b_reg      <= b_next;
        pu_x_reg   <= pu_x_next;
        rm_x_reg   <= rm_x_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        pu_k_reg   <= pu_k_next;
        need_reg   <= need_next;
        old_reg    <= old_next;
        lp_reg     <= lp_next;
        ln_reg     <= ln_next;
        status_reg <= status_next;
        rh_reg     <= rh_next;
        copy_reg   <= copy_next;
        src_reg    <= src_next;
        len_reg    <= len_next;
    end

    `ASSERT_IMPL(a_fail_no_grant, done && (status_reg != ST_OK), (rh_reg == '0) && !copy_reg)
    `ASSERT_NEXT(a_start_leaves_idle, start && (state_reg == S_IDLE), state_reg == S_DISPATCH)
    `ASSERT_NEXT(a_result_held, done && !ack, done && $stable(result))

endmodule

`default_nettype wire

[rtl/buddy_block_allocator_unit.sv]
// Top level of the buddy block allocator: stream handshakes and result register.
// Depends on bba_pkg and bba_ctrl (which holds the store and the shared adder).
//
//  channel  | valid / ready       | tdata (low bit first)                     | tuser
//  ---------+---------------------+-------------------------------------------+-------
//  request  | s_tvalid / s_tready | request_size[16:0], handle[32:17]          | kind
//  result   | m_tvalid / m_tready | status, result_handle, copy_needed,        | -
//           |                     | copy_source, copy_length, bytes_allocated, |
//           |                     | bytes_free                                 |
//
// One request is in work at a time; s_tready is high only while the sequencer is idle.
// How long an item holds the block depends on its path: an unused kind or a malformed
// handle ends it at dispatch and a handle that names no allocated block after the
// metadata read, while an alloc may scan and split through all thirteen orders,
// a free may merge up to the top and a realloc may move. Each split, list removal
// and merge is a run of accesses to the single-port metadata memories.
// Reset empties the pool to one free top block at once; there is no clearing pass.
// A finished result sits in the output register, so the next request is taken while it
// waits; a further result waits in the sequencer until the register is free.
`default_nettype none

module buddy_block_allocator_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // request_size [16:0], handle [32:17], zero fill above
    input  wire logic [bba_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind [1:0]
    input  wire logic [bba_pkg::KIND_W-1:0]       s_tuser,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // status [1:0], result_handle [17:2], copy_needed [18], copy_source [34:19],
    // copy_length [51:35], bytes_allocated [68:52], bytes_free [85:69], zero fill above
    output      logic [bba_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import bba_pkg::*;

    req_t                  req;
    result_t               res;
    logic                  idle, done, ack, start;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    assign req.kind         = s_tuser;
    assign req.request_size = s_tdata[SIZE_W-1:0];
    assign req.handle       = s_tdata[SIZE_W +: HANDLE_W];

    // The result register is free when empty or being emptied this cycle.
    assign ack = !m_valid_reg || m_tready;

    bba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .idle(idle), .done(done), .ack(ack), .result(res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (done && ack)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_DATA_W'({res.bytes_free, res.bytes_allocated, res.copy_length,
                                        res.copy_source, res.copy_needed, res.result_handle,
                                        res.status});
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the buddy block allocator unit: drives alloc, free and
// realloc requests on the stream input and checks every result against its own predictor.
// Depends on bba_pkg and buddy_block_allocator_unit.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam int NBLK      = BLOCK_COUNT;
    localparam int NO_LINK   = BLOCK_COUNT;
    localparam int CYC_LIMIT = 1500000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    buddy_block_allocator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor copy of the allocator metadata.
    bit            pool_used  [NBLK];
    int unsigned   pool_order [NBLK];
    int unsigned   pool_size  [NBLK];
    int unsigned   pool_prev  [NBLK];
    int unsigned   pool_next  [NBLK];
    int unsigned   free_head  [NUM_ORDERS];
    int unsigned   sum_alloc;
    int unsigned   sum_free;

    result_t       pending_results[$];
    bit            pending_known[$];   // 1 where the row also carries a typed-in result
    result_t       typed_results[$];
    int unsigned   live_handles[$];   // handles the predictor believes are allocated
    int            fail_count;
    int            cycle_count;
    int            result_count;
    bit            stall_hold;

    function automatic int unsigned blk_cap(int unsigned k);
        return MIN_BLOCK_BYTES << k;
    endfunction

    function automatic void list_unlink(int unsigned e);
        int unsigned p, n;
        p = pool_prev[e];
        n = pool_next[e];
        if (p >= NO_LINK)
            free_head[pool_order[e]] = n;
        else
            pool_next[p] = n;
        if (n < NO_LINK)
            pool_prev[n] = p;
    endfunction

    function automatic void list_front(int unsigned k, int unsigned e);
        int unsigned n;
        n = free_head[k];
        pool_used[e]  = 1'b0;
        pool_order[e] = k;
        pool_prev[e]  = NO_LINK;
        pool_next[e]  = n;
        if (n < NO_LINK)
            pool_prev[n] = e;
        free_head[k] = e;
    endfunction

    function automatic int unsigned free_buddy(int unsigned e, int unsigned k);
        int unsigned span, b;
        if (k >= TOP_ORDER)
            return NO_LINK;
        span = 1 << k;
        b = e ^ span;
        if (b >= NBLK || pool_used[b] || pool_order[b] != k)
            return NO_LINK;
        return b;
    endfunction

    function automatic bit take_block(int unsigned size, output int unsigned got);
        int unsigned k, i, e;
        k = 0;
        got = 0;
        while (k <= TOP_ORDER && blk_cap(k) < size + HEADER_BYTES)
            k++;
        if (k > TOP_ORDER)
            return 1'b0;
        for (i = k; i <= TOP_ORDER; i++) begin
            e = free_head[i];
            if (e >= NO_LINK)
                continue;
            list_unlink(e);
            while (i > k) begin
                i--;
                list_front(i, e + (1 << i));
            end
            pool_used[e]  = 1'b1;
            pool_order[e] = k;
            pool_size[e]  = size;
            sum_alloc += size;
            sum_free  -= blk_cap(k);
            got = e;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void give_back(int unsigned e);
        int unsigned k, b;
        k = pool_order[e];
        pool_used[e] = 1'b0;
        sum_alloc -= pool_size[e];
        sum_free  += blk_cap(k);
        b = free_buddy(e, k);
        while (b != NO_LINK) begin
            list_unlink(b);
            if (b < e)
                e = b;
            k++;
            b = free_buddy(e, k);
        end
        list_front(k, e);
    endfunction

    function automatic bit lookup_handle(int unsigned h, output int unsigned e);
        e = 0;
        if (h < HEADER_BYTES || (h - HEADER_BYTES) % MIN_BLOCK_BYTES != 0)
            return 1'b0;
        e = (h - HEADER_BYTES) / MIN_BLOCK_BYTES;
        if (e >= NBLK)
            return 1'b0;
        return pool_used[e];
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < NBLK; i++) begin
            pool_used[i]  = 1'b0;
            pool_order[i] = 0;
            pool_size[i]  = 0;
            pool_prev[i]  = 0;
            pool_next[i]  = 0;
        end
        for (int i = 0; i < NUM_ORDERS; i++)
            free_head[i] = NO_LINK;
        list_front(TOP_ORDER, 0);
        sum_alloc = 0;
        sum_free  = POOL_BYTES;
        live_handles.delete();
    endfunction

    function automatic void forget_handle(int unsigned h);
        foreach (live_handles[i])
            if (live_handles[i] == h) begin
                live_handles.delete(i);
                return;
            end
    endfunction

    // Works out the result of one request and updates the predictor state.
    function automatic result_t serve_request(logic [KIND_W-1:0] kind, int unsigned size,
                                              int unsigned h);
        result_t r;
        int unsigned e, ne, k, asz, cap, old, b;
        r = '0;
        if (kind == KIND_ALLOC) begin
            if (take_block(size, ne)) begin
                r.result_handle = handle_of(ENTRY_W'(ne));
                live_handles.push_back(32'(r.result_handle));
            end else
                r.status = ST_OOM;
        end else if (kind == KIND_FREE) begin
            if (lookup_handle(h, e)) begin
                give_back(e);
                forget_handle(h);
            end else
                r.status = ST_BADH;
        end else if (kind == KIND_REALLOC) begin
            if (!lookup_handle(h, e))
                r.status = ST_BADH;
            else if (size == 0) begin
                give_back(e);
                forget_handle(h);
            end else begin
                k   = pool_order[e];
                asz = size + HEADER_BYTES;
                cap = blk_cap(k);
                old = pool_size[e];
                b   = NO_LINK;
                if (asz > cap && asz <= cap * 2 && (e & (1 << k)) == 0)
                    b = free_buddy(e, k);
                if (asz <= cap) begin
                    sum_alloc = sum_alloc + size - old;
                    while (k > 0 && blk_cap(k - 1) >= asz) begin
                        k--;
                        list_front(k, e + (1 << k));
                        sum_free += blk_cap(k);
                    end
                    pool_order[e] = k;
                    pool_size[e]  = size;
                    r.result_handle = HANDLE_W'(h);
                end else if (b != NO_LINK) begin
                    sum_alloc = sum_alloc + size - old;
                    sum_free -= cap;
                    list_unlink(b);
                    pool_order[e] = k + 1;
                    pool_size[e]  = size;
                    r.result_handle = HANDLE_W'(h);
                end else if (take_block(size, ne)) begin
                    r.copy_needed = 1'b1;
                    r.copy_source = HANDLE_W'(h);
                    r.copy_length = SIZE_W'(old);
                    give_back(e);
                    forget_handle(h);
                    r.result_handle = handle_of(ENTRY_W'(ne));
                    live_handles.push_back(32'(r.result_handle));
                end else
                    r.status = ST_OOM;
            end
        end
        r.bytes_allocated = TOTAL_W'(sum_alloc);
        r.bytes_free      = TOTAL_W'(sum_free);
        return r;
    endfunction

    // Clock, reset and the overall cycle limit.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYC_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall_hold)
                m_tready <= 1'b0;
            else if (result_count > 600 && result_count < 900)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 18);
        end
    end

    initial begin
        stall_hold = 1'b0;
        wait (result_count >= 300);
        @(posedge clk);
        stall_hold = 1'b1;
        repeat (400) @(posedge clk);
        stall_hold = 1'b0;
    end

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk) begin
        result_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[OUT_RAW_W-1:0]);
            // m_tdata holds status in the lowest bits, so unpack by hand.
            got.status          = m_tdata[1:0];
            got.result_handle   = m_tdata[17:2];
            got.copy_needed     = m_tdata[18];
            got.copy_source     = m_tdata[34:19];
            got.copy_length     = m_tdata[51:35];
            got.bytes_allocated = m_tdata[68:52];
            got.bytes_free      = m_tdata[85:69];
            result_count++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (pending_known.pop_front()) begin
                    if (typed_results.pop_front() != want) begin
                        $error("typed-in result disagrees with the predictor");
                        fail_count++;
                    end
                end
                if (got.status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.result_handle != want.result_handle) begin
                    $error("result_handle: expected %0d, got %0d",
                           want.result_handle, got.result_handle);
                    fail_count++;
                end
                if (got.copy_needed != want.copy_needed) begin
                    $error("copy_needed: expected %0d, got %0d",
                           want.copy_needed, got.copy_needed);
                    fail_count++;
                end
                if (got.copy_source != want.copy_source) begin
                    $error("copy_source: expected %0d, got %0d",
                           want.copy_source, got.copy_source);
                    fail_count++;
                end
                if (got.copy_length != want.copy_length) begin
                    $error("copy_length: expected %0d, got %0d",
                           want.copy_length, got.copy_length);
                    fail_count++;
                end
                if (got.bytes_allocated != want.bytes_allocated) begin
                    $error("bytes_allocated: expected %0d, got %0d",
                           want.bytes_allocated, got.bytes_allocated);
                    fail_count++;
                end
                if (got.bytes_free != want.bytes_free) begin
                    $error("bytes_free: expected %0d, got %0d",
                           want.bytes_free, got.bytes_free);
                    fail_count++;
                end
                if (m_tdata[OUT_DATA_W-1:OUT_RAW_W] != '0) begin
                    $error("m_tdata fill: expected 0, got %0h",
                           m_tdata[OUT_DATA_W-1:OUT_RAW_W]);
                    fail_count++;
                end
            end
        end
    end

    // Directed rows: kind, size, handle, and a typed-in result where it is obvious.
    typedef struct {
        logic [KIND_W-1:0] kind;
        int unsigned       size;
        int unsigned       h;
        bit                known;
        result_t           res;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic dir_row_t row(logic [KIND_W-1:0] kind, int unsigned size,
                                     int unsigned h);
        dir_row_t d;
        d.kind  = kind;
        d.size  = size;
        d.h     = h;
        d.known = 1'b0;
        d.res   = '0;
        return d;
    endfunction

    function automatic dir_row_t row_k(logic [KIND_W-1:0] kind, int unsigned size,
                                       int unsigned h, logic [STATUS_W-1:0] st,
                                       int unsigned rh, int unsigned ba, int unsigned bf);
        dir_row_t d;
        d = row(kind, size, h);
        d.known = 1'b1;
        d.res.status          = st;
        d.res.result_handle   = HANDLE_W'(rh);
        d.res.bytes_allocated = TOTAL_W'(ba);
        d.res.bytes_free      = TOTAL_W'(bf);
        return d;
    endfunction

    int unsigned sent;

    // Sends one request, queueing its expected result at the moment it is accepted.
    task automatic send_item(logic [KIND_W-1:0] kind, int unsigned size, int unsigned h,
                             bit known, result_t res, bit busy_mode);
        if (!busy_mode)
            while ($urandom_range(99) < 18) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_DATA_W'({h[HANDLE_W-1:0], size[SIZE_W-1:0]});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(serve_request(kind, size, h));
        pending_known.push_back(known);
        if (known)
            typed_results.push_back(res);
        sent++;
    endtask

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(120);
        if (r < 85) return $urandom_range(1000);
        if (r < 97) return $urandom_range(8000);
        return $urandom_range(65536);
    endfunction

    // Noise handles are odd, so they are below the header or off a block boundary and
    // never name an entry that has not yet been written.
    function automatic int unsigned pick_handle();
        if (live_handles.size() > 0 && $urandom_range(99) < 85)
            return live_handles[$urandom_range(live_handles.size() - 1)];
        return $urandom_range(65535) | 1;
    endfunction

    initial begin
        logic [KIND_W-1:0] k;
        int unsigned       r;
        result_t           none;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_ALLOC;
        fail_count   = 0;
        result_count = 0;
        sent = 0;
        none = '0;
        pool_reset();

        // Extremes, bad handles, zero sizes and the realloc paths.
        dir_rows.push_back(row_k(KIND_ALLOC, 65536, 0, ST_OOM, 0, 0, 65536));
        dir_rows.push_back(row_k(KIND_FREE, 0, 8, ST_BADH, 0, 0, 65536));
        dir_rows.push_back(row_k(KIND_ALLOC, 65528, 0, ST_OK, 8, 65528, 0));
        dir_rows.push_back(row_k(KIND_ALLOC, 0, 0, ST_OOM, 0, 65528, 0));
        dir_rows.push_back(row_k(KIND_FREE, 0, 8, ST_OK, 0, 0, 65536));
        dir_rows.push_back(row_k(KIND_ALLOC, 0, 0, ST_OK, 8, 0, 65520));
        dir_rows.push_back(row_k(KIND_FREE, 0, 7, ST_BADH, 0, 0, 65520));
        dir_rows.push_back(row_k(KIND_FREE, 0, 9, ST_BADH, 0, 0, 65520));
        dir_rows.push_back(row_k(KIND_REALLOC, 5, 65535, ST_BADH, 0, 0, 65520));
        dir_rows.push_back(row_k(KIND_FREE, 0, 24, ST_BADH, 0, 0, 65520));
        dir_rows.push_back(row(KIND_REALLOC, 8, 8));
        dir_rows.push_back(row(KIND_REALLOC, 24, 8));
        dir_rows.push_back(row(KIND_ALLOC, 40, 0));
        dir_rows.push_back(row(KIND_REALLOC, 200, 8));
        dir_rows.push_back(row(KIND_REALLOC, 1, 8));
        dir_rows.push_back(row(KIND_REALLOC, 65536, 8));
        dir_rows.push_back(row(KIND_ALLOC, 1000, 0));
        dir_rows.push_back(row(KIND_REALLOC, 0, 8));
        dir_rows.push_back(row(2'd3, 131071, 65535));
        dir_rows.push_back(row(KIND_ALLOC, 131071, 0));
        dir_rows.push_back(row(KIND_REALLOC, 0, 32776));

        @(posedge rst_n);
        @(posedge clk);
        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].size, dir_rows[i].h,
                      dir_rows[i].known, dir_rows[i].res, 1'b0);

        // Random part: mostly alloc/free/realloc on live handles, some noise.
        for (int n = 0; n < 1700; n++) begin
            r = $urandom_range(99);
            if (r < 45 || live_handles.size() == 0)
                k = KIND_ALLOC;
            else if (r < 72)
                k = KIND_FREE;
            else if (r < 97)
                k = KIND_REALLOC;
            else
                k = 2'd3;
            send_item(k, pick_size(), pick_handle(), 1'b0, none,
                      (n >= 400 && n < 700));
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Ran %0d requests (alloc, free, realloc, bad handles, out of memory),", sent);
        $display("with random stalls on both sides and one long output hold-off.");
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_store.sv
rtl/bba_alu.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_unit.sv
test/testbench.sv
